### hdl/sparse_matvec_mod_prime_assert.svh
// assertion macros for the sparse mat-vec mod-prime block
// no dependencies; included by the top level
`ifndef SPARSE_MATVEC_MOD_PRIME_ASSERT_SVH
`define SPARSE_MATVEC_MOD_PRIME_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SMM_ASSERT_HOLDS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("smm assertion failed");

// antecedent implies consequent in the same cycle
`define SMM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smm assertion failed");

`endif

### hdl/smm_pkg.sv
// shared types and constants for the sparse mat-vec mod-prime block
// no dependencies
package smm_pkg;

    localparam int IDX_W    = 10;
    localparam int VAL_W    = 17;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int SHIFT_LO = 16;
    localparam int HI_W     = PROD_W - SHIFT_LO;
    localparam int SHIFT_Q  = 17;
    localparam int Q_W      = HI_W + VAL_W - SHIFT_Q;
    localparam int REM_W    = VAL_W + 2;

    // modulus and its scaled reciprocal floor(2^33 / p)
    localparam logic [VAL_W-1:0] PRIME = 17'd100003;
    localparam logic [VAL_W-1:0] RECIP = 17'd85896;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_NZ    = 2'd1;
    localparam logic [1:0] ACT_EMPTY = 2'd2;

    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;
    localparam int OQ_CW    = OQ_AW + 1;

    typedef struct packed {
        logic       vld;
        logic [1:0] action;
        logic       last;
    } t_tag;

    typedef struct packed {
        logic [IDX_W-1:0] row_number;
        logic [VAL_W-1:0] row_result;
    } t_result;

endpackage

### hdl/smm_in_if.sv
// input channel of the sparse mat-vec block: valid/ready plus item fields
// depends on smm_pkg
interface smm_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     action;
    logic [smm_pkg::IDX_W-1:0]      index;
    logic [smm_pkg::VAL_W-1:0]      value;
    logic                           last_in_row;

    modport source (output valid, action, index, value, last_in_row, input ready);
    modport sink   (input valid, action, index, value, last_in_row, output ready);
endinterface

### hdl/smm_out_if.sv
// output channel of the sparse mat-vec block: valid/ready plus row result
// depends on smm_pkg
interface smm_out_if;
    logic                           valid;
    logic                           ready;
    logic [smm_pkg::IDX_W-1:0]      row_number;
    logic [smm_pkg::VAL_W-1:0]      row_result;

    modport source (output valid, row_number, row_result, input ready);
    modport sink   (input valid, row_number, row_result, output ready);
endinterface

### hdl/smm_vec_store.sv
// vector store memory with registered read, and the input stage registers
// depends on smm_pkg
module smm_vec_store #(
    parameter int MAX_DIM = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_action,
    input  logic [smm_pkg::IDX_W-1:0]   i_index,
    input  logic [smm_pkg::VAL_W-1:0]   i_value,
    input  logic                        i_last,
    output smm_pkg::t_tag               o_tag,
    output logic [smm_pkg::VAL_W-1:0]   o_value,
    output logic [smm_pkg::VAL_W-1:0]   o_x,
    output logic                        o_x_ok
);
    localparam int DEPTH = (MAX_DIM < (1 << smm_pkg::IDX_W)) ? MAX_DIM
                                                             : (1 << smm_pkg::IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [smm_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [smm_pkg::VAL_W-1:0] r_x;
    logic [smm_pkg::VAL_W-1:0] r_value;
    logic                      r_x_ok;
    smm_pkg::t_tag             r_tag;
    smm_pkg::t_tag             n_tag;
    logic                      w_ok;
    logic [AW-1:0]             w_addr;
    logic                      w_we;

    assign w_ok   = 32'(i_index) < 32'(MAX_DIM);
    assign w_addr = w_ok ? i_index[AW-1:0] : '0;
    assign w_we   = i_accept && (i_action == smm_pkg::ACT_LOAD) && w_ok;

    always_comb begin
        n_tag.vld    = i_accept && ((i_action == smm_pkg::ACT_NZ) ||
                                    (i_action == smm_pkg::ACT_EMPTY));
        n_tag.action = i_action;
        n_tag.last   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= i_value;
        end
        r_x <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        r_value <= i_value;
        r_x_ok  <= w_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= n_tag;
        end
    end

    assign o_tag   = r_tag;
    assign o_value = r_value;
    assign o_x     = r_x;
    assign o_x_ok  = r_x_ok;
endmodule

### hdl/smm_mulmod.sv
// four-stage modular multiply: product, barrett quotient, q*p, correction
// depends on smm_pkg
module smm_mulmod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  smm_pkg::t_tag               i_tag,
    input  logic [smm_pkg::VAL_W-1:0]   i_a,
    input  logic [smm_pkg::VAL_W-1:0]   i_b,
    input  logic                        i_b_ok,
    output smm_pkg::t_tag               o_tag,
    output logic [smm_pkg::VAL_W-1:0]   o_rem
);
    localparam int QF_W  = smm_pkg::HI_W + smm_pkg::VAL_W;
    localparam int QP_W  = smm_pkg::Q_W + smm_pkg::VAL_W;

    logic [smm_pkg::VAL_W-1:0]  w_a_red;
    logic [smm_pkg::VAL_W-1:0]  w_b;
    logic [smm_pkg::VAL_W-1:0]  w_b_red;
    logic [QF_W-1:0]            w_qfull;
    logic [smm_pkg::PROD_W-1:0] w_diff;
    logic [smm_pkg::REM_W-1:0]  w_r;
    logic [smm_pkg::REM_W-1:0]  w_p1;
    logic [smm_pkg::REM_W-1:0]  w_p2;
    logic [smm_pkg::REM_W-1:0]  w_r_red;

    logic [smm_pkg::PROD_W-1:0] r_s1_prod;
    logic [smm_pkg::PROD_W-1:0] r_s2_prod;
    logic [smm_pkg::PROD_W-1:0] r_s3_prod;
    logic [smm_pkg::Q_W-1:0]    r_s2_q;
    logic [QP_W-1:0]            r_s3_qp;
    logic [smm_pkg::VAL_W-1:0]  r_s4_rem;
    smm_pkg::t_tag              r_s1_tag;
    smm_pkg::t_tag              r_s2_tag;
    smm_pkg::t_tag              r_s3_tag;
    smm_pkg::t_tag              r_s4_tag;

    // operands below 2^17 are below 2p, one subtract reduces them
    always_comb begin
        w_a_red = (i_a >= smm_pkg::PRIME) ? i_a - smm_pkg::PRIME : i_a;
        w_b     = i_b_ok ? i_b : '0;
        w_b_red = (w_b >= smm_pkg::PRIME) ? w_b - smm_pkg::PRIME : w_b;
    end

    assign w_qfull = QF_W'(r_s1_prod[smm_pkg::PROD_W-1:smm_pkg::SHIFT_LO])
                   * QF_W'(smm_pkg::RECIP);

    // quotient estimate is low by at most two, so remainder is below 3p
    always_comb begin
        w_diff  = r_s3_prod - r_s3_qp[smm_pkg::PROD_W-1:0];
        w_r     = w_diff[smm_pkg::REM_W-1:0];
        w_p1    = smm_pkg::REM_W'(smm_pkg::PRIME);
        w_p2    = smm_pkg::REM_W'({smm_pkg::PRIME, 1'b0});
        if (w_r >= w_p2) begin
            w_r_red = w_r - w_p2;
        end else if (w_r >= w_p1) begin
            w_r_red = w_r - w_p1;
        end else begin
            w_r_red = w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod <= smm_pkg::PROD_W'(w_a_red) * smm_pkg::PROD_W'(w_b_red);
        r_s2_prod <= r_s1_prod;
        r_s2_q    <= w_qfull[QF_W-1:smm_pkg::SHIFT_Q];
        r_s3_prod <= r_s2_prod;
        r_s3_qp   <= QP_W'(r_s2_q) * QP_W'(smm_pkg::PRIME);
        r_s4_rem  <= w_r_red[smm_pkg::VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_s3_tag <= '0;
            r_s4_tag <= '0;
        end else begin
            r_s1_tag <= i_tag;
            r_s2_tag <= r_s1_tag;
            r_s3_tag <= r_s2_tag;
            r_s4_tag <= r_s3_tag;
        end
    end

    assign o_tag = r_s4_tag;
    assign o_rem = r_s4_rem;
endmodule

### hdl/smm_outq.sv
// small result queue between the accumulator and the output channel
// depends on smm_pkg
module smm_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  smm_pkg::t_result            i_data,
    input  logic                        i_pop,
    output logic                        o_valid,
    output smm_pkg::t_result            o_data,
    output logic [smm_pkg::OQ_CW-1:0]   o_count
);
    smm_pkg::t_result            r_q [smm_pkg::OQ_DEPTH];
    logic [smm_pkg::OQ_AW-1:0]   r_wr;
    logic [smm_pkg::OQ_AW-1:0]   r_rd;
    logic [smm_pkg::OQ_CW-1:0]   r_count;
    logic                        w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + smm_pkg::OQ_CW'(i_push) - smm_pkg::OQ_CW'(w_pop);
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_q[r_rd];
    assign o_count = r_count;
endmodule

### hdl/sparse_matvec_mod_prime.sv
// top level of the streaming sparse matrix-vector product y = A*x mod 100003
// depends on smm_pkg, smm_in_if, smm_out_if, smm_vec_store, smm_mulmod, smm_outq
//
// usage: first stream load beats (action 0) that write x[index] = value into
// the vector store, then stream the matrix row by row as nonzero beats
// (action 1, index = column) with last_in_row on the final nonzero of each
// row; an empty row is a single action 2 beat. each finished row leaves on
// the output channel as one beat carrying row_number and row_result.
// throughput: one input beat per cycle, sustained, while the output side
// keeps up. an input beat passes through the store read, three multiply/reduce
// stages, final correction, then the result queue on its way to the output.
// the row sum update is a single add and compare-subtract, so rows can
// follow one another with no gap.
// stall: a credit counter tracks results accepted but not yet delivered;
// ready drops when it reaches the 8-entry queue depth, so a stalled
// receiver stops the input after at most 8 pending rows, never losing one.
// reset (i_rst_n low, synchronous) clears row sum, row counter, pipeline
// valid bits, credit and queue; the vector store keeps its contents and
// must be loaded before use.
`include "sparse_matvec_mod_prime_assert.svh"

module sparse_matvec_mod_prime #(
    parameter int MAX_DIM = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    smm_in_if.sink        i_in,
    smm_out_if.source     o_out
);
    // input stage outputs
    smm_pkg::t_tag                 w_a_tag;
    logic [smm_pkg::VAL_W-1:0]     w_a_value;
    logic [smm_pkg::VAL_W-1:0]     w_a_x;
    logic                          w_a_x_ok;

    // multiply/reduce outputs
    smm_pkg::t_tag                 w_m_tag;
    logic [smm_pkg::VAL_W-1:0]     w_m_rem;

    // accumulator
    logic [smm_pkg::VAL_W-1:0]     r_row_sum;
    logic [smm_pkg::VAL_W-1:0]     n_row_sum;
    logic [smm_pkg::IDX_W-1:0]     r_row_cnt;
    logic [smm_pkg::IDX_W-1:0]     n_row_cnt;
    logic [smm_pkg::VAL_W:0]       w_sum;
    logic [smm_pkg::VAL_W-1:0]     w_sum_red;
    logic                          w_push;
    smm_pkg::t_result              w_push_data;

    // credit and queue
    logic [smm_pkg::OQ_CW-1:0]     r_credit;
    logic [smm_pkg::OQ_CW-1:0]     n_credit;
    logic                          w_in_acc;
    logic                          w_in_res;
    logic                          w_out_acc;
    logic                          w_oq_valid;
    smm_pkg::t_result              w_oq_data;
    logic [smm_pkg::OQ_CW-1:0]     w_oq_count;

    // input handshake, ready is purely a function of the credit register
    assign i_in.ready = r_credit < smm_pkg::OQ_CW'(smm_pkg::OQ_DEPTH);
    assign w_in_acc   = i_in.valid && i_in.ready;
    // beats that will end in exactly one result
    assign w_in_res   = w_in_acc &&
                        ((i_in.action == smm_pkg::ACT_EMPTY) ||
                         ((i_in.action == smm_pkg::ACT_NZ) && i_in.last_in_row));

    smm_vec_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_acc),
        .i_action (i_in.action),
        .i_index  (i_in.index),
        .i_value  (i_in.value),
        .i_last   (i_in.last_in_row),
        .o_tag    (w_a_tag),
        .o_value  (w_a_value),
        .o_x      (w_a_x),
        .o_x_ok   (w_a_x_ok)
    );

    smm_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_a_tag),
        .i_a     (w_a_value),
        .i_b     (w_a_x),
        .i_b_ok  (w_a_x_ok),
        .o_tag   (w_m_tag),
        .o_rem   (w_m_rem)
    );

    // running row sum: both terms below p, one compare-subtract keeps it reduced
    always_comb begin
        w_sum     = {1'b0, r_row_sum} + {1'b0, w_m_rem};
        w_sum_red = (w_sum >= {1'b0, smm_pkg::PRIME})
                  ? smm_pkg::VAL_W'(w_sum - {1'b0, smm_pkg::PRIME})
                  : w_sum[smm_pkg::VAL_W-1:0];
        n_row_sum   = r_row_sum;
        w_push      = 1'b0;
        w_push_data.row_number = r_row_cnt;
        w_push_data.row_result = w_sum_red;
        if (w_m_tag.vld) begin
            case (w_m_tag.action)
                smm_pkg::ACT_NZ: begin
                    n_row_sum = w_m_tag.last ? '0 : w_sum_red;
                    w_push    = w_m_tag.last;
                end
                smm_pkg::ACT_EMPTY: begin
                    // empty row drops any partial sum and reports zero
                    n_row_sum              = '0;
                    w_push                 = 1'b1;
                    w_push_data.row_result = '0;
                end
                default: begin
                    n_row_sum = r_row_sum;
                end
            endcase
        end
        n_row_cnt = w_push ? r_row_cnt + 1'b1 : r_row_cnt;
    end

    smm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (o_out.ready),
        .o_valid (w_oq_valid),
        .o_data  (w_oq_data),
        .o_count (w_oq_count)
    );

    assign o_out.valid      = w_oq_valid;
    assign o_out.row_number = w_oq_data.row_number;
    assign o_out.row_result = w_oq_data.row_result;
    assign w_out_acc        = w_oq_valid && o_out.ready;

    assign n_credit = r_credit + smm_pkg::OQ_CW'(w_in_res) - smm_pkg::OQ_CW'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
            r_row_cnt <= '0;
            r_credit  <= '0;
        end else begin
            r_row_sum <= n_row_sum;
            r_row_cnt <= n_row_cnt;
            r_credit  <= n_credit;
        end
    end

    // credit never passes the queue depth
    `SMM_ASSERT_HOLDS(a_credit_bound, i_clk, i_rst_n, r_credit <= smm_pkg::OQ_CW'(smm_pkg::OQ_DEPTH))
    // a push always finds room in the queue
    `SMM_ASSERT_IMPLIES(a_push_room, i_clk, i_rst_n, w_push, w_oq_count < smm_pkg::OQ_CW'(smm_pkg::OQ_DEPTH))
    // queued results are always covered by credit
    `SMM_ASSERT_HOLDS(a_queue_credit, i_clk, i_rst_n, w_oq_count <= r_credit)
    // row sum stays reduced
    `SMM_ASSERT_HOLDS(a_sum_reduced, i_clk, i_rst_n, r_row_sum < smm_pkg::PRIME)

endmodule
